@@ sv/sti_pkg.sv @@
// Shared types and constants for the sorted table insert block.
package sti_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int KEY_W         = 32;
	localparam int CMD_W         = 2;
	localparam int POS_W         = 11;
	localparam int CAP_W         = 11;
	localparam int APB_DW        = 32;
	localparam int APB_AW        = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1000;

	// register index taken from the word address bit
	localparam logic REG_CAP_LIMIT = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_INSERT = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
	} rsp_t;

endpackage

@@ sv/sti_ram.sv @@
// Single write port, single registered read port memory for the table entries.
module sti_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one word, read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sorted_table_insert.sv @@
// Top level: sorted table of signed words with clear, append and ordered insert.
//
// An item is taken when start is high and busy is low. Clear, append and the
// unused command code finish in the cycle they are taken; their result strobe
// (done) comes in the next cycle and busy stays low, so a new item can follow
// at once. An insert that is refused as full behaves the same way. Any other
// insert raises busy and walks the table one entry per cycle through the
// memory read port and signed equal and greater-than compares, moving larger
// entries up one place as it goes, until it reaches the end of the table. A
// duplicate ends the walk early at the matching entry. done is high for
// exactly one cycle and cannot be held off, so the receiver must take every
// result as it appears. The entry memory needs no clearing pass after reset;
// the fill count is reset, the entries are not.
module sorted_table_insert
	import sti_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	// result channel
	output logic              done,
	output rsp_t              rsp,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	state_t                  state_q, state_d;
	logic [CW-1:0]           fill_q, fill_d;
	logic [CW-1:0]           idx_q, idx_d;
	logic [CW-1:0]           pos_q, pos_d;
	logic                    placed_q, placed_d;
	logic [KEY_W-1:0]        carry_q, carry_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [CAP_W-1:0]        cap_q;
	logic                    done_q, done_d;
	rsp_t                    rsp_q, rsp_d;

	logic                    accept;
	logic                    cfg_wr;
	logic                    full_app;
	logic                    full_ins;
	logic [LW-1:0]           lim_eff;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [KEY_W-1:0]        ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [KEY_W-1:0]        ram_rdata;

	// entry storage
	sti_ram #(
		.DEPTH (DEPTH),
		.WIDTH (KEY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAP_LIMIT);
	assign prdata = (paddr[2] == REG_CAP_LIMIT) ? APB_DW'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// capacity checks: insert honors the limit clamped to DEPTH, append only DEPTH
	assign lim_eff  = (LW'(cap_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_q);
	assign full_ins = LW'(fill_q) >= lim_eff;
	assign full_app = fill_q == CW'(DEPTH);

	assign accept = start && !busy;
	assign busy   = (state_q == S_SCAN);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// sequencer: next state, memory access and result
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		placed_d  = placed_q;
		carry_d   = carry_q;
		key_d     = key_q;
		done_d    = 1'b0;
		rsp_d     = rsp_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = carry_q;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				// keep entry 0 on the read port so a scan can start at once
				ram_raddr = '0;
				if (accept) begin
					unique case (req.cmd)
						CMD_CLEAR: begin
							fill_d         = '0;
							done_d         = 1'b1;
							rsp_d.status   = ST_DONE;
							rsp_d.position = '0;
						end
						CMD_APPEND: begin
							done_d = 1'b1;
							if (full_app) begin
								rsp_d.status   = ST_FULL;
								rsp_d.position = '0;
							end else begin
								ram_we         = 1'b1;
								ram_waddr      = fill_q[AW-1:0];
								ram_wdata      = req.key;
								fill_d         = fill_q + CW'(1);
								rsp_d.status   = ST_DONE;
								rsp_d.position = POS_W'(fill_q);
							end
						end
						CMD_INSERT: begin
							if (full_ins) begin
								done_d         = 1'b1;
								rsp_d.status   = ST_FULL;
								rsp_d.position = '0;
							end else begin
								key_d    = req.key;
								idx_d    = '0;
								placed_d = 1'b0;
								state_d  = S_SCAN;
							end
						end
						default: begin
							done_d         = 1'b1;
							rsp_d.status   = ST_DONE;
							rsp_d.position = '0;
						end
					endcase
				end
			end
			S_SCAN: begin
				// fetch the next entry while the current one is handled
				ram_raddr = AW'(idx_q + CW'(1));
				priority if (idx_q == fill_q) begin
					// end of table: store the last carried word or the key itself
					ram_we         = 1'b1;
					ram_waddr      = idx_q[AW-1:0];
					ram_wdata      = placed_q ? carry_q : key_q;
					fill_d         = fill_q + CW'(1);
					done_d         = 1'b1;
					rsp_d.status   = ST_DONE;
					rsp_d.position = placed_q ? POS_W'(pos_q) : POS_W'(idx_q);
					state_d        = S_IDLE;
				end else if (placed_q) begin
					// shift: drop the carried word here, carry this entry up
					ram_we    = 1'b1;
					ram_wdata = carry_q;
					carry_d   = ram_rdata;
					idx_d     = idx_q + CW'(1);
				end else if ($signed(ram_rdata) == key_q) begin
					done_d         = 1'b1;
					rsp_d.status   = ST_DUP;
					rsp_d.position = '0;
					state_d        = S_IDLE;
				end else if ($signed(ram_rdata) > key_q) begin
					// first larger entry: key goes here, this entry starts moving up
					ram_we    = 1'b1;
					ram_wdata = key_q;
					carry_d   = ram_rdata;
					placed_d  = 1'b1;
					pos_d     = idx_q;
					idx_d     = idx_q + CW'(1);
				end else begin
					idx_d = idx_q + CW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			done_q   <= 1'b0;
			placed_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			done_q   <= done_d;
			placed_q <= placed_d;
			idx_q    <= idx_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		carry_q <= carry_d;
		key_q   <= key_d;
		rsp_q   <= rsp_d;
	end

endmodule

@@ sv/sti_checker.sv @@
// Port-level checks for the sorted table insert block, bound to the top level.
module sti_checker
	import sti_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// every taken item either answers next cycle or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("item taken but neither done nor busy next cycle");

	// a finished scan always reports
	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// results appear only once the block has stopped working
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// every result traces back to a taken item or a running scan
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a preceding item");

	// refused or duplicate items carry position zero
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_DONE)) |-> (rsp.position == '0))
		else $error("nonzero position on a refused item");

endmodule

bind sorted_table_insert sti_checker u_sti_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
